// ===== rtl/trmx_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package trmx_pkg;

	typedef logic signed [13:0] trig_t;
	typedef logic [10:0] dim_t;
	typedef logic signed [31:0] word_t;

	localparam int FRAC_BITS = 12;
	localparam int CENTER_SHIFT = 3;
	localparam int TRANS_SHIFT = 4;
	localparam logic signed [15:0] FX_ONE = 16'sd4096;

	// Divider: quotient bits resolved per stage and number of stages
	localparam int DIV_STEPS = 2;
	localparam int DIV_STAGES = 12;
	localparam int QUO_W = DIV_STAGES * DIV_STEPS;

	// Input register, divider stages, product stage, output stage
	localparam int NUM_STAGES = DIV_STAGES + 3;

	typedef logic [QUO_W-1:0] quo_t;
	typedef logic [NUM_STAGES-1:0] stage_vec_t;

	typedef struct packed {
		trig_t sine;
		trig_t cosine;
		word_t shift_s;
		word_t shift_t;
		dim_t  tex_width;
		dim_t  tex_height;
		logic  wid_zero;
		logic  hgt_zero;
	} side_t;

endpackage
`default_nettype wire

// ===== rtl/trmx_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface trmx_in_if;
	logic           valid;
	logic           ready;
	trmx_pkg::trig_t sine;
	trmx_pkg::trig_t cosine;
	trmx_pkg::word_t shift_s;
	trmx_pkg::word_t shift_t;
	trmx_pkg::dim_t  tex_width;
	trmx_pkg::dim_t  tex_height;

	modport source (output valid, sine, cosine, shift_s, shift_t, tex_width, tex_height,
		input ready);
	modport sink (input valid, sine, cosine, shift_s, shift_t, tex_width, tex_height,
		output ready);
endinterface

interface trmx_out_if;
	logic           valid;
	logic           ready;
	trmx_pkg::trig_t diag_term;
	trmx_pkg::word_t upper_off_term;
	trmx_pkg::word_t lower_off_term;
	trmx_pkg::word_t trans_s_term;
	trmx_pkg::word_t trans_t_term;

	modport source (output valid, diag_term, upper_off_term, lower_off_term, trans_s_term,
		trans_t_term, input ready);
	modport sink (input valid, diag_term, upper_off_term, lower_off_term, trans_s_term,
		trans_t_term, output ready);
endinterface
`default_nettype wire

// ===== rtl/trmx_ctl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module trmx_ctl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	input  wire logic                 out_ready,
	output trmx_pkg::stage_vec_t      en,
	output logic                      in_ready,
	output logic                      out_valid
);

	trmx_pkg::stage_vec_t vld_q;
	trmx_pkg::stage_vec_t vld_d;

	// A stage loads when it is empty or its word moves on
	always_comb begin
		en[trmx_pkg::NUM_STAGES-1] = !vld_q[trmx_pkg::NUM_STAGES-1] || out_ready;
		for (int k = trmx_pkg::NUM_STAGES - 2; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	assign vld_d = {vld_q[trmx_pkg::NUM_STAGES-2:0], in_valid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= (en & vld_d) | (~en & vld_q);
		end
	end

	assign in_ready  = en[0];
	assign out_valid = vld_q[trmx_pkg::NUM_STAGES-1];

endmodule
`default_nettype wire

// ===== rtl/trmx_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module trmx_div (
	input  wire logic                              clk,
	input  wire logic [trmx_pkg::DIV_STAGES-1:0]   en,
	input  trmx_pkg::dim_t                         num,
	input  trmx_pkg::dim_t                         den,
	output trmx_pkg::quo_t                         quo
);

	trmx_pkg::dim_t rem_s [trmx_pkg::DIV_STAGES];
	trmx_pkg::quo_t acc_s [trmx_pkg::DIV_STAGES];
	trmx_pkg::dim_t den_s [trmx_pkg::DIV_STAGES];

	for (genvar g = 0; g < trmx_pkg::DIV_STAGES; g++) begin : g_stage
		trmx_pkg::dim_t rem_in;
		trmx_pkg::quo_t acc_in;
		trmx_pkg::dim_t den_in;
		trmx_pkg::dim_t rem_nx;
		trmx_pkg::quo_t acc_nx;
		logic [11:0]    trial;

		if (g == 0) begin : g_first
			// Numerator is num shifted up by the fraction bits
			assign rem_in = '0;
			assign acc_in = trmx_pkg::quo_t'({num, {trmx_pkg::FRAC_BITS{1'b0}}});
			assign den_in = den;
		end else begin : g_next
			assign rem_in = rem_s[g-1];
			assign acc_in = acc_s[g-1];
			assign den_in = den_s[g-1];
		end

		// Restoring steps: shift in a numerator bit, subtract when it fits
		always_comb begin
			rem_nx = rem_in;
			acc_nx = acc_in;
			trial  = '0;
			for (int i = 0; i < trmx_pkg::DIV_STEPS; i++) begin
				trial  = {rem_nx, acc_nx[trmx_pkg::QUO_W-1]};
				acc_nx = {acc_nx[trmx_pkg::QUO_W-2:0], 1'b0};
				if (trial >= {1'b0, den_in}) begin
					rem_nx    = 11'(trial - {1'b0, den_in});
					acc_nx[0] = 1'b1;
				end else begin
					rem_nx = trial[10:0];
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en[g]) begin
				rem_s[g] <= rem_nx;
				acc_s[g] <= acc_nx;
				den_s[g] <= den_in;
			end
		end
	end

	assign quo = acc_s[trmx_pkg::DIV_STAGES-1];

endmodule
`default_nettype wire

// ===== rtl/trmx_mac.sv =====
`timescale 1ns / 1ps
`default_nettype none
module trmx_mac (
	input  wire logic           clk,
	input  wire logic [1:0]     en,
	input  trmx_pkg::side_t     side,
	input  trmx_pkg::quo_t      ratio_hw,
	input  trmx_pkg::quo_t      ratio_wh,
	output trmx_pkg::trig_t     diag_term,
	output trmx_pkg::word_t     upper_off_term,
	output trmx_pkg::word_t     lower_off_term,
	output trmx_pkg::word_t     trans_s_term,
	output trmx_pkg::word_t     trans_t_term
);

	trmx_pkg::quo_t     rhw;
	trmx_pkg::quo_t     rwh;
	logic signed [15:0] ctr_a;
	logic signed [15:0] ctr_b;
	logic signed [38:0] mul_up;
	logic signed [38:0] mul_lo;
	logic signed [27:0] mul_a;
	logic signed [27:0] mul_b;
	logic signed [43:0] mul_ts;
	logic signed [43:0] mul_tt;

	trmx_pkg::trig_t cos_s14;
	trmx_pkg::word_t prod_up_s14;
	trmx_pkg::word_t prod_lo_s14;
	trmx_pkg::word_t prod_a_s14;
	trmx_pkg::word_t prod_b_s14;
	trmx_pkg::word_t prod_ts_s14;
	trmx_pkg::word_t prod_tt_s14;
	trmx_pkg::word_t neg_up;

	// Zero divisor gives a zero ratio
	assign rhw = side.wid_zero ? '0 : ratio_hw;
	assign rwh = side.hgt_zero ? '0 : ratio_wh;

	assign ctr_a = trmx_pkg::FX_ONE - side.sine - side.cosine;
	assign ctr_b = side.sine - side.cosine + trmx_pkg::FX_ONE;

	assign mul_up = side.sine * $signed({1'b0, rhw});
	assign mul_lo = side.sine * $signed({1'b0, rwh});
	assign mul_a  = ctr_a * $signed({1'b0, side.tex_width});
	assign mul_b  = ctr_b * $signed({1'b0, side.tex_height});
	assign mul_ts = side.shift_s * $signed({1'b0, side.tex_width});
	assign mul_tt = side.shift_t * $signed({1'b0, side.tex_height});

	always_ff @(posedge clk) begin
		if (en[0]) begin
			cos_s14     <= side.cosine;
			prod_up_s14 <= mul_up[31:0];
			prod_lo_s14 <= mul_lo[31:0];
			prod_a_s14  <= 32'(mul_a);
			prod_b_s14  <= 32'(mul_b);
			prod_ts_s14 <= mul_ts[31:0];
			prod_tt_s14 <= mul_tt[31:0];
		end
	end

	assign neg_up = -prod_up_s14;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			diag_term      <= cos_s14;
			upper_off_term <= neg_up >>> trmx_pkg::FRAC_BITS;
			lower_off_term <= prod_lo_s14 >>> trmx_pkg::FRAC_BITS;
			trans_s_term   <= (prod_a_s14 <<< trmx_pkg::CENTER_SHIFT)
				- (prod_ts_s14 <<< trmx_pkg::TRANS_SHIFT);
			trans_t_term   <= (prod_b_s14 <<< trmx_pkg::CENTER_SHIFT)
				+ (prod_tt_s14 <<< trmx_pkg::TRANS_SHIFT);
		end
	end

endmodule
`default_nettype wire

// ===== rtl/texture_rotation_matrix_aspect_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Texture rotation matrix terms with aspect correction.
// Input channel "item" carries sine and cosine (2.12), the s and t shifts and
// the texture width and height; output channel "result" carries the diagonal
// term, the two aspect-scaled off-diagonal terms and the translation row.
// Both channels use valid/ready; a word moves when both are high.
// The pipeline is 15 register stages: an input register, 12 divider stages
// that each resolve two bits of height*4096/width and width*4096/height,
// a multiplier stage and an output register. One item is taken every cycle
// while the result side does not stall.
// Each stage holds its word while the stage after it is full and stalled, so
// a stall on the result side fills the bubbles first and then drops ready on
// the item side; nothing is lost or repeated.
// Reset clears the valid bits only; the block is empty and ready after it.
module texture_rotation_matrix_aspect_unit (
	input  wire logic   clk,
	input  wire logic   arst_n,
	trmx_in_if.sink     item,
	trmx_out_if.source  result
);

	trmx_pkg::stage_vec_t en;
	trmx_pkg::side_t      side_s1;
	trmx_pkg::side_t      side_d [trmx_pkg::DIV_STAGES];
	trmx_pkg::quo_t       ratio_hw;
	trmx_pkg::quo_t       ratio_wh;

	trmx_ctl u_ctl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.out_ready (result.ready),
		.en        (en),
		.in_ready  (item.ready),
		.out_valid (result.valid)
	);

	always_ff @(posedge clk) begin
		if (en[0]) begin
			side_s1.sine       <= item.sine;
			side_s1.cosine     <= item.cosine;
			side_s1.shift_s    <= item.shift_s;
			side_s1.shift_t    <= item.shift_t;
			side_s1.tex_width  <= item.tex_width;
			side_s1.tex_height <= item.tex_height;
			side_s1.wid_zero   <= (item.tex_width == '0);
			side_s1.hgt_zero   <= (item.tex_height == '0);
		end
	end

	// Carry the item alongside the dividers
	for (genvar g = 0; g < trmx_pkg::DIV_STAGES; g++) begin : g_side
		if (g == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (en[1]) begin
					side_d[0] <= side_s1;
				end
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				if (en[g+1]) begin
					side_d[g] <= side_d[g-1];
				end
			end
		end
	end

	trmx_div u_div_hw (
		.clk (clk),
		.en  (en[trmx_pkg::DIV_STAGES:1]),
		.num (side_s1.tex_height),
		.den (side_s1.tex_width),
		.quo (ratio_hw)
	);

	trmx_div u_div_wh (
		.clk (clk),
		.en  (en[trmx_pkg::DIV_STAGES:1]),
		.num (side_s1.tex_width),
		.den (side_s1.tex_height),
		.quo (ratio_wh)
	);

	trmx_mac u_mac (
		.clk            (clk),
		.en             (en[trmx_pkg::NUM_STAGES-1:trmx_pkg::NUM_STAGES-2]),
		.side           (side_d[trmx_pkg::DIV_STAGES-1]),
		.ratio_hw       (ratio_hw),
		.ratio_wh       (ratio_wh),
		.diag_term      (result.diag_term),
		.upper_off_term (result.upper_off_term),
		.lower_off_term (result.lower_off_term),
		.trans_s_term   (result.trans_s_term),
		.trans_t_term   (result.trans_t_term)
	);

endmodule
`default_nettype wire
